FILE: rtl/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared types, constants and register codes of the box blur frame unit.
// ----------------------------------------------------------------------------
package bbf_pkg;

  localparam int CFG_DIM_W      = 10;
  localparam int KSIZE_W        = 5;
  localparam int CH_W           = 8;
  localparam int OUT_W          = 10;
  localparam int PIX_W          = 3 * CH_W;
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int RST_DIM        = 512;
  localparam int RST_KSIZE      = 3;
  localparam int KSIZE_MAX      = 31;
  localparam int WIN_MAX        = (2 * (KSIZE_MAX / 2) + 1) * (2 * (KSIZE_MAX / 2) + 1);
  localparam int SUM_W          = $clog2(WIN_MAX * 255 + 1);
  localparam int DIV_W          = $clog2(KSIZE_MAX * KSIZE_MAX + 1);
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 4;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KSIZE  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic            mode;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
    logic             last_pixel;
  } out_word_t;

endpackage

FILE: rtl/bbf_ram.sv
// ----------------------------------------------------------------------------
// bbf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bbf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bbf_div.sv
// ----------------------------------------------------------------------------
// bbf_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbf_div #(
  parameter int NUM_W = 18,
  parameter int DEN_W = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/box_blur_frame_unit.sv
// ----------------------------------------------------------------------------
// box_blur_frame_unit
// Box blur over a stored RGB frame: loads pixels, returns blurred pixels.
// ----------------------------------------------------------------------------
// Usage: an input word is taken at a rising edge with start high and busy
// low. A mode-0 word writes one pixel into the frame store in raster order;
// busy stays low. A mode-1 word starts the blur of the next output pixel:
// busy rises and the result appears on res_o with res_strobe_o high for
// exactly one cycle, the first cycle with busy low. The window, clipped to
// the frame and up to 31 x 31, is read from the frame store one pixel a
// cycle; then one shared restoring divider handles the three channels in
// turn, one quotient bit a cycle. The receiver cannot stall; results are
// never held back. Configuration goes through the APB port (frame_width at
// 0x0, frame_height at 0x4, kernel_size at 0x8); the user must write it
// only while idle, as the block itself does not enforce it. A dimension
// write restarts load and output positions. Reset clears the positions and
// registers to their defaults; the store is undefined until loaded and
// needs no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_frame_unit
  import bbf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  in_word_t          in_i,
  output logic              res_strobe_o,
  output out_word_t         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int WX_W   = $clog2(MAX_WIDTH + 1);
  localparam int HX_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int EXT_A  = (WX_W > HX_W) ? WX_W : HX_W;
  localparam int EXT_W  = (EXT_A > CFG_DIM_W) ? EXT_A : CFG_DIM_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_READ  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_DGO   = 6'b010000,
    ST_DWAIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CFG_DIM_W-1:0] width_q, height_q;
  logic [KSIZE_W-1:0]   ksize_q;

  logic [EXT_W-1:0] w_ext, h_ext, w_clip, h_clip;
  logic [WX_W-1:0]  eff_w;
  logic [HX_W-1:0]  eff_h;
  logic [COL_W-1:0] w_m1;
  logic [ROW_W-1:0] h_m1;

  logic [ADDR_W-1:0] load_idx_q;
  logic [COL_W-1:0]  load_col_q, out_col_q;
  logic [ROW_W-1:0]  load_row_q, out_row_q;

  logic [ROW_W-1:0]  row_q, r1_q;
  logic [COL_W-1:0]  col_q, c0_q, c1_q;
  logic [ADDR_W-1:0] base_q;
  logic [DIV_W-1:0]  div_q;
  logic              last_q;
  logic              rvalid_q;
  logic [1:0]        ch_q;
  logic [SUM_W-1:0]  sum_r_q, sum_g_q, sum_b_q;
  logic              strobe_q;
  out_word_t         res_q;

  logic              acc, load_acc, blur_acc, cfg_wr;
  reg_idx_e          reg_idx;
  logic [KSIZE_W-1:0] size, half;
  logic [ROW_W-1:0]  r0, r1;
  logic [COL_W-1:0]  c0, c1;
  logic [ROW_W:0]    row_sum;
  logic [COL_W:0]    col_sum;
  logic              is_last;
  logic [PIX_W-1:0]  rdata;
  logic [ADDR_W-1:0] raddr;
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_num, div_quo;

  // effective frame dimensions
  always_comb begin
    w_ext  = EXT_W'(width_q);
    h_ext  = EXT_W'(height_q);
    w_clip = (w_ext == '0) ? EXT_W'(1) :
             (w_ext > EXT_W'(MAX_WIDTH)) ? EXT_W'(MAX_WIDTH) : w_ext;
    h_clip = (h_ext == '0) ? EXT_W'(1) :
             (h_ext > EXT_W'(MAX_HEIGHT)) ? EXT_W'(MAX_HEIGHT) : h_ext;
    eff_w  = WX_W'(w_clip);
    eff_h  = HX_W'(h_clip);
    w_m1   = COL_W'(eff_w - WX_W'(1));
    h_m1   = ROW_W'(eff_h - HX_W'(1));
  end

  assign acc      = start && !busy;
  assign load_acc = acc && !in_i.mode;
  assign blur_acc = acc && in_i.mode;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign reg_idx  = reg_idx_e'(paddr[3:2]);

  // window bounds of the next output pixel
  always_comb begin
    size    = (ksize_q == '0) ? KSIZE_W'(1) : ksize_q;
    half    = size >> 1;
    r0      = (out_row_q > ROW_W'(half)) ? out_row_q - ROW_W'(half) : '0;
    c0      = (out_col_q > COL_W'(half)) ? out_col_q - COL_W'(half) : '0;
    row_sum = {1'b0, out_row_q} + (ROW_W + 1)'(half);
    col_sum = {1'b0, out_col_q} + (COL_W + 1)'(half);
    r1      = (row_sum > {1'b0, h_m1}) ? h_m1 : row_sum[ROW_W-1:0];
    c1      = (col_sum > {1'b0, w_m1}) ? w_m1 : col_sum[COL_W-1:0];
    is_last = (out_row_q == h_m1) && (out_col_q == w_m1);
  end

  // configuration registers and positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= CFG_DIM_W'(RST_DIM);
      height_q   <= CFG_DIM_W'(RST_DIM);
      ksize_q    <= KSIZE_W'(RST_KSIZE);
      load_idx_q <= '0;
      load_col_q <= '0;
      load_row_q <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
    end else begin
      if (load_acc) begin
        if (load_col_q == w_m1) begin
          load_col_q <= '0;
          if (load_row_q == h_m1) begin
            load_row_q <= '0;
            load_idx_q <= '0;
          end else begin
            load_row_q <= load_row_q + ROW_W'(1);
            load_idx_q <= load_idx_q + ADDR_W'(1);
          end
        end else begin
          load_col_q <= load_col_q + COL_W'(1);
          load_idx_q <= load_idx_q + ADDR_W'(1);
        end
      end
      if (blur_acc) begin
        if (is_last) begin
          out_col_q <= '0;
          out_row_q <= '0;
        end else if (out_col_q == w_m1) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + ROW_W'(1);
        end else begin
          out_col_q <= out_col_q + COL_W'(1);
        end
      end
      if (cfg_wr) begin
        case (reg_idx)
          REG_WIDTH, REG_HEIGHT: begin
            if (reg_idx == REG_WIDTH) begin
              width_q <= pwdata[CFG_DIM_W-1:0];
            end else begin
              height_q <= pwdata[CFG_DIM_W-1:0];
            end
            load_idx_q <= '0;
            load_col_q <= '0;
            load_row_q <= '0;
            out_col_q  <= '0;
            out_row_q  <= '0;
          end
          REG_KSIZE: begin
            ksize_q <= pwdata[KSIZE_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      REG_KSIZE:  prdata = APB_DW'(ksize_q);
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // sequencer
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (blur_acc) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = ST_READ;
      end
      ST_READ: begin
        if (row_q == r1_q && col_q == c1_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DGO;
      end
      ST_DGO: begin
        div_start = 1'b1;
        state_d   = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          state_d = (ch_q == 2'd2) ? ST_IDLE : ST_DGO;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rvalid_q <= 1'b0;
      strobe_q <= 1'b0;
      ch_q     <= '0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= state_q == ST_READ;
      strobe_q <= (state_q == ST_DWAIT) && div_done && (ch_q == 2'd2);
      if (state_q == ST_SETUP) begin
        ch_q <= '0;
      end else if (state_q == ST_DWAIT && div_done) begin
        ch_q <= ch_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (blur_acc) begin
      row_q  <= r0;
      r1_q   <= r1;
      col_q  <= c0;
      c0_q   <= c0;
      c1_q   <= c1;
      div_q  <= DIV_W'(size) * DIV_W'(size);
      last_q <= is_last;
    end
    if (state_q == ST_SETUP) begin
      base_q  <= ADDR_W'(ADDR_W'(row_q) * ADDR_W'(eff_w));
      sum_r_q <= '0;
      sum_g_q <= '0;
      sum_b_q <= '0;
    end
    if (state_q == ST_READ) begin
      if (col_q == c1_q) begin
        col_q  <= c0_q;
        row_q  <= row_q + ROW_W'(1);
        base_q <= base_q + ADDR_W'(eff_w);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
    if (rvalid_q) begin
      sum_r_q <= sum_r_q + SUM_W'(rdata[3*CH_W-1:2*CH_W]);
      sum_g_q <= sum_g_q + SUM_W'(rdata[2*CH_W-1:CH_W]);
      sum_b_q <= sum_b_q + SUM_W'(rdata[CH_W-1:0]);
    end
    if (state_q == ST_DWAIT && div_done) begin
      case (ch_q)
        2'd0:    res_q.red_out   <= div_quo[OUT_W-1:0];
        2'd1:    res_q.green_out <= div_quo[OUT_W-1:0];
        default: res_q.blue_out  <= div_quo[OUT_W-1:0];
      endcase
      res_q.last_pixel <= last_q;
    end
  end

  assign raddr = base_q + ADDR_W'(col_q);

  always_comb begin
    case (ch_q)
      2'd0:    div_num = sum_r_q;
      2'd1:    div_num = sum_g_q;
      default: div_num = sum_b_q;
    endcase
  end

  bbf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (load_idx_q),
    .wdata_i ({in_i.red_in, in_i.green_in, in_i.blue_in}),
    .re_i    (state_q == ST_READ),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  bbf_div #(
    .NUM_W (SUM_W),
    .DEN_W (DIV_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign busy         = state_q != ST_IDLE;
  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o)
    else $error("result strobe longer than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> !busy)
    else $error("result strobe while busy");

  a_load_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !in_i.mode) |=> !busy)
    else $error("load word made the unit busy");

  a_blur_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.mode) |=> (busy && !res_strobe_o))
    else $error("blur word did not start the sequencer");

endmodule
